### sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define CSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/csb_pkg.sv
package csb_pkg;

  // buffer geometry
  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned ERR_W    = 2;

  // action codes, unused codes behave as query
  typedef enum logic [ACT_W-1:0] {
    ACT_START   = 3'd0,
    ACT_ADVANCE = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_ATTACH  = 3'd3,
    ACT_REMOVE  = 3'd4,
    ACT_QUERY   = 3'd5
  } action_e;

  // error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_NOCUR = 2'd2
  } error_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the accepted item
    logic exec;  // apply the action to the buffer
    logic read;  // register the result fields
  } csb_cmd_t;

endpackage

### sv/csb_ctrl.sv
module csb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  output csb_pkg::csb_cmd_t  cmd_o
);
  import csb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   accept;

  assign accept = start_i && !busy_q;

  // state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          done_q <= 1'b0;
          if (accept) begin
            state_q <= ST_EXEC;
            busy_q  <= 1'b1;
          end
        end
        ST_EXEC: begin
          state_q <= ST_READ;
          done_q  <= 1'b0;
        end
        ST_READ: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd_o.load = accept;
    cmd_o.exec = (state_q == ST_EXEC);
    cmd_o.read = (state_q == ST_READ);
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

### sv/csb_datapath.sv
module csb_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  csb_pkg::csb_cmd_t            cmd_i,
  input  logic [csb_pkg::ACT_W-1:0]    action_i,
  input  logic [csb_pkg::DATA_W-1:0]   entry_value_i,
  output logic [csb_pkg::DATA_W-1:0]   current_value_o,
  output logic                         has_current_o,
  output logic [csb_pkg::CNT_W-1:0]    item_count_o,
  output logic [csb_pkg::CNT_W-1:0]    cursor_pos_o,
  output logic [csb_pkg::ERR_W-1:0]    error_code_o
);
  import csb_pkg::*;

  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  // captured item
  logic [ACT_W-1:0]  act_q;
  logic [DATA_W-1:0] val_q;

  // buffer state
  logic [DATA_W-1:0] cells_q [CAPACITY];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cursor_q, cursor_d;
  logic [ERR_W-1:0]  err_q, err_d;

  // result registers
  logic [DATA_W-1:0] res_val_q;
  logic              res_cur_q;
  logic [CNT_W-1:0]  res_cnt_q;
  logic [CNT_W-1:0]  res_pos_q;
  logic [ERR_W-1:0]  res_err_q;

  logic             cur;
  logic             full;
  logic             do_ins;
  logic             do_rem;
  logic [CNT_W-1:0] pos;
  logic [IDX_W-1:0] pos_idx;
  logic             cur_now;

  // capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      val_q <= entry_value_i;
    end
  end

  // action decode: new cursor, count, error and shift request
  always_comb begin
    cur      = (cursor_q < count_q);
    full     = (count_q >= CapCnt);
    cursor_d = cursor_q;
    count_d  = count_q;
    err_d    = ERR_OK;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    pos      = cursor_q;
    case (act_q)
      ACT_START: begin
        if (count_q != '0) cursor_d = '0;
      end
      ACT_ADVANCE: begin
        if (cur) cursor_d = cursor_q + CNT_W'(1);
        else     err_d    = ERR_NOCUR;
      end
      ACT_INSERT: begin
        if (full) begin
          err_d = ERR_FULL;
        end else begin
          pos      = cur ? cursor_q : '0;
          cursor_d = pos;
          count_d  = count_q + CNT_W'(1);
          do_ins   = 1'b1;
        end
      end
      ACT_ATTACH: begin
        if (full) begin
          err_d = ERR_FULL;
        end else begin
          pos      = cur ? (cursor_q + CNT_W'(1)) : count_q;
          cursor_d = pos;
          count_d  = count_q + CNT_W'(1);
          do_ins   = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (cur) begin
          count_d = count_q - CNT_W'(1);
          do_rem  = 1'b1;
        end else begin
          err_d = ERR_NOCUR;
        end
      end
      default: begin
      end
    endcase
  end

  // position below capacity whenever a shift happens
  assign pos_idx = pos[IDX_W-1:0];

  // row of cells: each cell loads from its neighbor or the new word
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.exec) begin
        if (do_ins) begin
          if (IDX_W'(i) == pos_idx) begin
            cells_q[i] <= val_q;
          end else if (i > 0 && IDX_W'(i) > pos_idx) begin
            cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
          end
        end else if (do_rem) begin
          if (i < CAPACITY - 1 && IDX_W'(i) >= pos_idx) begin
            cells_q[i] <= cells_q[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  // count, cursor and error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      err_q    <= ERR_OK;
    end else if (cmd_i.exec) begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      err_q    <= err_d;
    end
  end

  // result read at the cursor
  assign cur_now = (cursor_q < count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      res_val_q <= cur_now ? cells_q[cursor_q[IDX_W-1:0]] : '0;
      res_cur_q <= cur_now;
      res_cnt_q <= count_q;
      res_pos_q <= cursor_q;
      res_err_q <= err_q;
    end
  end

  assign current_value_o = res_val_q;
  assign has_current_o   = res_cur_q;
  assign item_count_o    = res_cnt_q;
  assign cursor_pos_o    = res_pos_q;
  assign error_code_o    = res_err_q;

endmodule

### sv/cursor_sequence_buffer.sv
// channel   | ports                                       | transfer
// ----------+---------------------------------------------+---------------------------
// command   | start_i, busy_o, action_i, entry_value_i    | start_i && !busy_o
// result    | done_o, current_value_o, has_current_o,     | done_o, one cycle, no hold
//           | item_count_o, cursor_pos_o, error_code_o    |
//
// each action runs through capture, update of the cell row and a registered read
// at the cursor; the result strobe follows and busy_o drops in that same cycle,
// so a new command may be taken while its result is shown.
// the cell row shifts all entries at once, so insert and remove take no longer than other actions.
// reset clears count and cursor; cell contents stay undefined until written.
// the receiver cannot stall: each result is valid for exactly one cycle.
module cursor_sequence_buffer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [csb_pkg::ACT_W-1:0]    action_i,
  input  logic [csb_pkg::DATA_W-1:0]   entry_value_i,
  output logic                         done_o,
  output logic [csb_pkg::DATA_W-1:0]   current_value_o,
  output logic                         has_current_o,
  output logic [csb_pkg::CNT_W-1:0]    item_count_o,
  output logic [csb_pkg::CNT_W-1:0]    cursor_pos_o,
  output logic [csb_pkg::ERR_W-1:0]    error_code_o
);
  import csb_pkg::*;

  `include "assert_macros.svh"

  csb_cmd_t cmd;

  // sequencing
  csb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // buffer and result registers
  csb_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .action_i        (action_i),
    .entry_value_i   (entry_value_i),
    .current_value_o (current_value_o),
    .has_current_o   (has_current_o),
    .item_count_o    (item_count_o),
    .cursor_pos_o    (cursor_pos_o),
    .error_code_o    (error_code_o)
  );

  // result consistency and sequencing checks
  `CSB_ASSERT(a_cursor_in_range, done_o |-> (cursor_pos_o <= item_count_o && item_count_o <= CNT_W'(CAPACITY)), "cursor or count out of range")
  `CSB_ASSERT(a_has_current, done_o |-> (has_current_o == (cursor_pos_o < item_count_o)), "has_current mismatch")
  `CSB_ASSERT(a_full_refusal, (done_o && error_code_o == ERR_FULL) |-> (item_count_o == CNT_W'(CAPACITY)), "full refusal below capacity")
  `CSB_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o && !done_o, "accepted command did not raise busy")

endmodule
